/* hw/rtl/sidq_pkg.sv */
// ----------------------------------------------------------------------------
// sidq_pkg - shared types for the sorted insert deque engine
// Opcode, status and sequencer state codes, and the command bundle that is
// broadcast to every list cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sidq_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [2:0] {
      OP_APPEND   = 3'd0,
      OP_INSERT   = 3'd1,
      OP_SEARCH   = 3'd2,
      OP_DELETE   = 3'd3,
      OP_CLEAR    = 3'd4,
      OP_POP_HEAD = 3'd5,
      OP_POP_TAIL = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_MISS  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_EXEC   = 2'd1,
      SEQ_REPORT = 2'd2
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  key;
      logic                      update;
   } cmd_type;

endpackage : sidq_pkg

`default_nettype wire

/* hw/rtl/sidq_cell.sv */
// ----------------------------------------------------------------------------
// sidq_cell - one list slot
// Holds one entry, compares it with the broadcast key, passes the first-hit
// flag to its right neighbor and shifts in from the left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module sidq_cell import sidq_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int INDEX    = 0
) (
   input  wire logic                                 clock,
   input  wire cmd_type                              cmd,
   input  wire logic [$clog2(CAPACITY+1)-1:0]        count,
   input  wire logic signed [DATA_W-1:0]             left_value,
   input  wire logic signed [DATA_W-1:0]             right_value,
   input  wire logic                                 carry_in,
   output logic signed [DATA_W-1:0]                  value_out,
   output logic                                      carry_out
);

   localparam int CW = $clog2(CAPACITY+1);
   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     occupied;
   logic                     mark;

   assign occupied  = (count > MY_INDEX);
   assign value_out = value_ff;
   assign carry_out = carry_in | mark;

   always_comb begin
      if (cmd.op == OP_INSERT) begin
         mark = (occupied && !(value_ff < cmd.key)) || (count == MY_INDEX);
      end else begin
         mark = occupied && (value_ff == cmd.key);
      end
   end

   always_comb begin
      value_in = value_ff;
      if (cmd.update) begin
         unique case (cmd.op)
            OP_APPEND: begin
               if (count == MY_INDEX) value_in = cmd.key;
            end
            OP_INSERT: begin
               if (carry_in)  value_in = left_value;
               else if (mark) value_in = cmd.key;
            end
            OP_DELETE: begin
               if (carry_in || mark) value_in = right_value;
            end
            OP_POP_HEAD: begin
               value_in = right_value;
            end
            default: begin
               value_in = value_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule : sidq_cell

`default_nettype wire

/* hw/rtl/sorted_insert_deque_engine.sv */
// ----------------------------------------------------------------------------
// sorted_insert_deque_engine - ordered list with deque and sorted insert
// Row of list cells with a shared key broadcast and a first-hit chain.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_opcode, req_key_value) is taken on a rising edge with
//   start high and busy low. Busy is high for one cycle while the cells
//   compare, shift and update. The next cycle shows the result on the rsp_
//   ports for exactly one cycle with rsp_valid high; that same cycle busy is
//   low again and a new request may be issued.
//   Each request takes the compare-and-shift pass through the cell row
//   (SEQ_EXEC) and then the report cycle (SEQ_REPORT); a new request is
//   taken in the report cycle or while idle, never during the pass.
//   The result cannot be held off; the receiver must take it while
//   rsp_valid is high.
//   Reset empties the list (entry count zero) and returns to idle; cell
//   contents are not cleared and are never read before they are written.
//   Head and tail outputs read 0 while the list is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_deque_engine import sidq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [2:0]                        req_opcode,
   input  wire logic signed [DATA_W-1:0]          req_key_value,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic signed [DATA_W-1:0]               rsp_result_value,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_entry_count,
   output logic                                   rsp_is_empty,
   output logic signed [DATA_W-1:0]               rsp_head_value,
   output logic signed [DATA_W-1:0]               rsp_tail_value
);

   localparam int CW = $clog2(CAPACITY+1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   state_type                state_ff;
   state_type                state_in;
   op_type                   op_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   status_type               status_ff;
   status_type               status_in;
   logic signed [DATA_W-1:0] result_ff;
   logic signed [DATA_W-1:0] result_in;
   logic                     accept;
   logic                     exec;
   logic                     update;
   logic                     found;
   logic                     empty;
   logic                     full;
   logic signed [DATA_W-1:0] tail_value;
   cmd_type                  cmd;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic                     carry      [CAPACITY+1];

   assign accept = start && !busy;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == FULL_COUNT);
   assign found  = carry[CAPACITY];

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:   if (accept) state_in = SEQ_EXEC;
         SEQ_EXEC:   state_in = SEQ_REPORT;
         SEQ_REPORT: state_in = accept ? SEQ_EXEC : SEQ_IDLE;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff == SEQ_EXEC);
      exec      = (state_ff == SEQ_EXEC);
      rsp_valid = (state_ff == SEQ_REPORT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_opcode);
         key_ff <= req_key_value;
      end
   end

   // command evaluation
   always_comb begin
      status_in = STAT_OK;
      result_in = '0;
      count_in  = count_ff;
      update    = 1'b0;
      unique case (op_ff)
         OP_APPEND, OP_INSERT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               update   = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_SEARCH: begin
            if (found) result_in = key_ff;
            else       status_in = STAT_MISS;
         end
         OP_DELETE: begin
            if (found) begin
               update    = 1'b1;
               result_in = key_ff;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = STAT_MISS;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_POP_HEAD: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               update    = 1'b1;
               result_in = cell_value[0];
               count_in  = count_ff - CW'(1);
            end
         end
         OP_POP_TAIL: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               result_in = tail_value;
               count_in  = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_comb begin
      cmd.op     = op_ff;
      cmd.key    = key_ff;
      cmd.update = exec && update;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff <= status_in;
         result_ff <= result_in;
      end
   end

   // cell row
   assign carry[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = key_ff;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end

      if (i == CAPACITY-1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end

      sidq_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_value  (left_v),
         .right_value (right_v),
         .carry_in    (carry[i]),
         .value_out   (cell_value[i]),
         .carry_out   (carry[i+1])
      );
   end

   // tail select, one-hot on count
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (count_ff == CW'(i + 1)) tail_value = tail_value | cell_value[i];
      end
   end

   always_comb begin
      rsp_status       = status_ff;
      rsp_result_value = result_ff;
      rsp_entry_count  = count_ff;
      rsp_is_empty     = empty;
      rsp_head_value   = empty ? '0 : cell_value[0];
      rsp_tail_value   = tail_value;
   end

endmodule : sorted_insert_deque_engine

`default_nettype wire

/* tb/sv/sorted_insert_deque_engine_tb.sv */
// ----------------------------------------------------------------------------
// sorted_insert_deque_engine_tb - self-checking bench for the deque engine
// Sends list commands through the start/busy port and predicts every response
// from a local copy of the ordered list. Each rsp_valid cycle is compared
// against the oldest prediction. Directed cases cover empty and full lists,
// extreme keys and the unused opcode. Random traffic then alternates between
// growing and shrinking the list, with idle bursts on the request side.
// ----------------------------------------------------------------------------
module sorted_insert_deque_engine_tb import sidq_pkg::*;;

   localparam int          CAPACITY    = 16;
   localparam int          CNT_W       = $clog2(CAPACITY + 1);
   localparam int          STALL_LIMIT = 500;
   localparam logic [2:0]  OP_UNUSED   = 3'd7;
   localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  value;
      logic [CNT_W-1:0]          count;
      logic                      empty;
      logic signed [DATA_W-1:0]  head;
      logic signed [DATA_W-1:0]  tail;
   } list_rsp_type;

   logic                        clock;
   logic                        reset         = 1'b1;
   logic                        start         = 1'b0;
   logic [2:0]                  req_opcode    = '0;
   logic signed [DATA_W-1:0]    req_key_value = '0;
   logic                        busy;
   logic                        rsp_valid;
   logic [1:0]                  rsp_status;
   logic signed [DATA_W-1:0]    rsp_result_value;
   logic [CNT_W-1:0]            rsp_entry_count;
   logic                        rsp_is_empty;
   logic signed [DATA_W-1:0]    rsp_head_value;
   logic signed [DATA_W-1:0]    rsp_tail_value;

   // local copy of the list
   logic signed [DATA_W-1:0]    list_entries [CAPACITY];
   int                          list_fill = 0;
   list_rsp_type                pending_rsp [$];

   int  requests_sent   = 0;
   int  results_checked = 0;
   int  fail_count      = 0;
   int  reported        = 0;
   int  full_rejects    = 0;
   int  empty_pops      = 0;
   int  key_hits        = 0;
   int  stall_cycles    = 0;
   bit  idle_on         = 1'b0;

   logic signed [DATA_W-1:0] key_pool [8] = '{KEY_MIN, KEY_MAX, 32'sd0, -32'sd1,
                                              32'sd1, 32'sd7, -32'sd7, 32'sd100};

   sorted_insert_deque_engine #(.CAPACITY(CAPACITY)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_key_value    (req_key_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_head_value   (rsp_head_value),
      .rsp_tail_value   (rsp_tail_value)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void drop_entry(input int pos);
      for (int i = pos; i + 1 < list_fill; i++)
         list_entries[i] = list_entries[i + 1];
      list_fill--;
   endfunction

   function automatic int find_key(input logic signed [DATA_W-1:0] key);
      for (int i = 0; i < list_fill; i++)
         if (list_entries[i] == key)
            return i;
      return list_fill;
   endfunction

   function automatic list_rsp_type apply_list_cmd(input logic [2:0] op,
                                                   input logic signed [DATA_W-1:0] key);
      list_rsp_type r;
      int           pos;
      r.status = STAT_OK;
      r.value  = '0;
      case (op)
         OP_APPEND: begin
            if (list_fill >= CAPACITY) begin
               r.status = STAT_FULL;
               full_rejects++;
            end else begin
               list_entries[list_fill] = key;
               list_fill++;
            end
         end
         OP_INSERT: begin
            if (list_fill >= CAPACITY) begin
               r.status = STAT_FULL;
               full_rejects++;
            end else begin
               pos = 0;
               while (pos < list_fill && list_entries[pos] < key)
                  pos++;
               for (int i = list_fill; i > pos; i--)
                  list_entries[i] = list_entries[i - 1];
               list_entries[pos] = key;
               list_fill++;
            end
         end
         OP_SEARCH, OP_DELETE: begin
            pos = find_key(key);
            if (pos < list_fill) begin
               r.value = list_entries[pos];
               key_hits++;
               if (op == OP_DELETE)
                  drop_entry(pos);
            end else begin
               r.status = STAT_MISS;
            end
         end
         OP_CLEAR: list_fill = 0;
         OP_POP_HEAD, OP_POP_TAIL: begin
            if (list_fill == 0) begin
               r.status = STAT_EMPTY;
               empty_pops++;
            end else if (op == OP_POP_HEAD) begin
               r.value = list_entries[0];
               drop_entry(0);
            end else begin
               r.value = list_entries[list_fill - 1];
               list_fill--;
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(list_fill);
      r.empty = (list_fill == 0);
      r.head  = (list_fill == 0) ? '0 : list_entries[0];
      r.tail  = (list_fill == 0) ? '0 : list_entries[list_fill - 1];
      return r;
   endfunction

   // start stays high across back-to-back requests; only idle_gap and the end of the run lower it
   task automatic send_request(input logic [2:0] op, input logic signed [DATA_W-1:0] key);
      start         <= 1'b1;
      req_opcode    <= op;
      req_key_value <= key;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      pending_rsp.push_back(apply_list_cmd(op, key));
      requests_sent++;
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 3);
      start         <= 1'b0;
      req_opcode    <= 3'($urandom);
      req_key_value <= $urandom;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return key_pool[$urandom_range(0, 7)];
      if (r < 7 && list_fill > 0)
         return list_entries[$urandom_range(0, list_fill - 1)];
      return $urandom;
   endfunction

   task automatic test_empty_list();
      send_request(OP_POP_HEAD, KEY_MAX);
      send_request(OP_POP_TAIL, KEY_MIN);
      send_request(OP_SEARCH, 32'sd0);
      send_request(OP_DELETE, -32'sd1);
      send_request(OP_UNUSED, 32'sd5);
   endtask

   task automatic test_fill_and_full();
      send_request(OP_APPEND, KEY_MAX);
      send_request(OP_INSERT, KEY_MIN);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_INSERT, -32'sd1);
      while (list_fill < CAPACITY)
         send_request(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND, $urandom);
      send_request(OP_APPEND, 32'sd3);
      send_request(OP_INSERT, KEY_MIN);
      send_request(OP_SEARCH, KEY_MAX);
      send_request(OP_DELETE, KEY_MIN);
      send_request(OP_POP_HEAD, 32'sd0);
      send_request(OP_POP_TAIL, 32'sd0);
      send_request(OP_CLEAR, 32'sd0);
   endtask

   task automatic test_random_traffic(input int n_items, input bit allow_idle);
      int         grow_bias;
      int         r;
      logic [2:0] op;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            grow_bias = $urandom_range(20, 80);
            idle_on   = allow_idle && ($urandom_range(0, 2) != 0);
         end
         r = $urandom_range(0, 99);
         if (r < 2)
            op = OP_UNUSED;
         else if (r < 5)
            op = OP_CLEAR;
         else if ($urandom_range(0, 99) < grow_bias)
            op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND;
         else
            case ($urandom_range(0, 3))
               0:       op = OP_SEARCH;
               1:       op = OP_DELETE;
               2:       op = OP_POP_HEAD;
               default: op = OP_POP_TAIL;
            endcase
         send_request(op, pick_key());
         if (idle_on && $urandom_range(0, 2) == 0)
            idle_gap();
      end
   endtask

   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         got = '{status_type'(rsp_status), rsp_result_value, rsp_entry_count,
                 rsp_is_empty, rsp_head_value, rsp_tail_value};
         results_checked++;
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (reported++ < 10)
               $display("ERROR: response with nothing outstanding at %0t", $realtime);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               fail_count++;
               if (reported++ < 10) begin
                  $display("ERROR: mismatch at %0t: exp st=%0d val=%0d cnt=%0d emp=%0b head=%0d tail=%0d",
                           $realtime, want.status, want.value, want.count, want.empty,
                           want.head, want.tail);
                  $display("       got st=%0d val=%0d cnt=%0d emp=%0b head=%0d tail=%0d",
                           got.status, got.value, got.count, got.empty, got.head, got.tail);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or response for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_fill_and_full();
      test_random_traffic(600, 1'b1);
      test_random_traffic(100, 1'b0);
      start <= 1'b0;
      guard = 0;
      while (pending_rsp.size() > 0 && guard < 100) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (pending_rsp.size() > 0) begin
         fail_count += pending_rsp.size();
         $display("ERROR: %0d responses never arrived", pending_rsp.size());
      end
      $display("Ran %0d list commands, checked %0d responses (%0d failures).",
               requests_sent, results_checked, fail_count);
      $display("Saw %0d full-list rejects, %0d pops on an empty list, %0d key hits.",
               full_rejects, empty_pops, key_hits);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
